>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Same, with a caller-supplied message.
`define ASSERT_ERR(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_ERR(name, clk, rst_n, prop, msg)
`endif

`endif

>>> hw/rtl/rqdp_pkg.sv
package rqdp_pkg;

  // Stream payload widths
  localparam int unsigned DataW    = 64;
  localparam int unsigned DistW    = 5;
  localparam int unsigned OpW      = 3;
  localparam int unsigned CntOutW  = 4;
  localparam int unsigned InTdataW = 72;
  localparam int unsigned OutTdataW = 72;

  // Operation codes carried on the input tuser
  typedef enum logic [OpW-1:0] {
    OP_ENQ       = 3'd0,
    OP_ENQ_DROP  = 3'd1,
    OP_DEQ       = 3'd2,
    OP_PEEK_OLD  = 3'd3,
    OP_PEEK_NEW  = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  // Status of one finished request, held in the result stage
  typedef struct packed {
    logic               ok;
    logic               rsel;      // read data comes from the slot store
    logic [CntOutW-1:0] count;
    logic               is_empty;
    logic               is_full;
  } res_meta_t;

endpackage

>>> hw/rtl/ring_queue_drop_peek_top.sv
// Ring queue with drop-oldest enqueue and peek from either end.
// A request accepted at a clock edge is registered in the result register, then
// presented on m_axis from the output register (via the skid entry if m_axis holds).
// Throughput: one request per cycle unless m_axis back-pressure stalls it; the slot
// store has one write and one registered read port, and each request uses at most one.
// Reset: head and tail pointers go to zero (queue empty); slots are not cleared.
`include "assert_macros.svh"

module ring_queue_drop_peek_top import rqdp_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned ENTRY_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [63:0] entry_data, [68:64] distance, [71:69] zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // [2:0] opcode
  input  logic [OpW-1:0]       s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] ok, [64:1] read_data, [68:65] count, [69] is_empty, [70] is_full,
  // [71] zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic                   mem_we, mem_re;
  logic [PTR_W-1:0]       mem_waddr, mem_raddr;
  logic [ENTRY_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                   res_vld, skid_rdy;
  res_meta_t              res_meta;
  logic [DataW-1:0]       read_data;
  logic [OutTdataW-1:0]   res_data;

  rqdp_ctrl #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH),
    .PTR_W       (PTR_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .opcode_i     (s_axis_tuser),
    .entry_data_i (s_axis_tdata[DataW-1:0]),
    .distance_i   (s_axis_tdata[DataW+DistW-1:DataW]),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .res_valid_o  (res_vld),
    .res_ready_i  (skid_rdy),
    .res_meta_o   (res_meta)
  );

  rqdp_mem #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH),
    .PTR_W       (PTR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Read data is zero unless this request read a slot
  assign read_data = res_meta.rsel ? DataW'(mem_rdata) : '0;
  assign res_data  = {1'b0, res_meta.is_full, res_meta.is_empty, res_meta.count,
                      read_data, res_meta.ok};

  rqdp_skid #(
    .W (OutTdataW)
  ) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_vld),
    .in_ready_o  (skid_rdy),
    .in_data_i   (res_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // A request uses the write port or the read port, never both
  `ASSERT_CLK(a_mem_port_excl, clk_i, rst_ni, !(mem_we && mem_re))
  // A stalled result keeps its slot and its status
  `ASSERT_ERR(a_res_hold, clk_i, rst_ni, (res_vld && !skid_rdy) |=> (res_vld && $stable(res_meta)), "result lost under stall")
  // Skid entry only fills behind a held output
  `ASSERT_CLK(a_skid_behind_out, clk_i, rst_ni, !skid_rdy |-> m_axis_tvalid)

endmodule

>>> hw/rtl/rqdp_mem.sv
module rqdp_mem import rqdp_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned ENTRY_WIDTH = 64,
  parameter int unsigned PTR_W       = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [PTR_W-1:0]       waddr_i,
  input  logic [ENTRY_WIDTH-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [PTR_W-1:0]       raddr_i,
  output logic [ENTRY_WIDTH-1:0] rdata_o
);

  logic [ENTRY_WIDTH-1:0] mem_q [DEPTH];
  logic [ENTRY_WIDTH-1:0] rdata_q;

  // One write and one registered read port; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rqdp_ctrl.sv
module rqdp_ctrl import rqdp_pkg::*; #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned ENTRY_WIDTH = 64,
  parameter int unsigned PTR_W       = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request side
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  logic [OpW-1:0]         opcode_i,
  input  logic [DataW-1:0]       entry_data_i,
  input  logic [DistW-1:0]       distance_i,
  // slot store ports
  output logic                   mem_we_o,
  output logic [PTR_W-1:0]       mem_waddr_o,
  output logic [ENTRY_WIDTH-1:0] mem_wdata_o,
  output logic                   mem_re_o,
  output logic [PTR_W-1:0]       mem_raddr_o,
  // result stage
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output res_meta_t              res_meta_o
);

  localparam int unsigned CW = (PTR_W > CntOutW) ? PTR_W : CntOutW;
  localparam int unsigned NW = (PTR_W > DistW) ? PTR_W : DistW;
  localparam logic [PTR_W-1:0] LastIdx = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DepthW  = (PTR_W+1)'(DEPTH);

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] held(input logic [PTR_W-1:0] h,
                                           input logic [PTR_W-1:0] t);
    logic [PTR_W:0] diff;
    diff = {1'b0, t} - {1'b0, h};
    if (t < h) diff = diff + DepthW;
    return diff[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic             res_vld_q, res_vld_d;
  res_meta_t        meta_q;

  logic             fire;
  logic             full_cur, empty_cur, in_range;
  logic [PTR_W-1:0] cnt_cur, cnt_d, nxt_tail, nxt_head;
  logic [NW-1:0]    n_ext, cnt_cur_ext;
  logic [PTR_W-1:0] n_p;
  logic [PTR_W:0]   old_sum, new_sum, tail_inc;
  logic [PTR_W-1:0] old_addr, new_addr;
  logic [CW-1:0]    cnt_wide;
  logic             we, re, ok;
  logic [PTR_W-1:0] raddr;

  // Accept when the result stage is free or drains this cycle
  assign req_ready_o = !res_vld_q || res_ready_i;
  assign fire        = req_valid_i && req_ready_o;

  // Current status
  assign cnt_cur   = held(head_q, tail_q);
  assign full_cur  = (wrap_next(tail_q) == head_q);
  assign empty_cur = (head_q == tail_q);
  assign nxt_tail  = wrap_next(tail_q);
  assign nxt_head  = wrap_next(head_q);

  // Peek range check and slot addresses
  assign n_ext       = NW'(distance_i);
  assign cnt_cur_ext = NW'(cnt_cur);
  assign in_range    = (n_ext != '0) && (n_ext <= cnt_cur_ext);
  assign n_p         = n_ext[PTR_W-1:0];

  always_comb begin
    old_sum = {1'b0, head_q} + {1'b0, n_p};
    if (old_sum >= DepthW) old_sum = old_sum - DepthW;
    old_addr = old_sum[PTR_W-1:0];

    tail_inc = {1'b0, tail_q} + 1'b1;
    if (tail_inc >= {1'b0, n_p}) new_sum = tail_inc - {1'b0, n_p};
    else                         new_sum = tail_inc + DepthW - {1'b0, n_p};
    new_addr = new_sum[PTR_W-1:0];
  end

  // Operation decode
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    we     = 1'b0;
    re     = 1'b0;
    ok     = 1'b0;
    raddr  = nxt_head;
    case (op_e'(opcode_i))
      OP_ENQ: begin
        if (!full_cur) begin
          tail_d = nxt_tail;
          we     = 1'b1;
          ok     = 1'b1;
        end
      end
      OP_ENQ_DROP: begin
        if (full_cur) head_d = nxt_head;
        tail_d = nxt_tail;
        we     = 1'b1;
        ok     = 1'b1;
      end
      OP_DEQ: begin
        if (!empty_cur) begin
          head_d = nxt_head;
          re     = 1'b1;
          ok     = 1'b1;
        end
      end
      OP_PEEK_OLD: begin
        raddr = old_addr;
        if (in_range) begin
          re = 1'b1;
          ok = 1'b1;
        end
      end
      OP_PEEK_NEW: begin
        raddr = new_addr;
        if (in_range) begin
          re = 1'b1;
          ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        ok     = 1'b1;
      end
      default: begin
        // unused codes leave the queue untouched
      end
    endcase
  end

  assign cnt_d    = held(head_d, tail_d);
  assign cnt_wide = CW'(cnt_d);

  assign mem_we_o    = fire && we;
  assign mem_waddr_o = nxt_tail;
  assign mem_wdata_o = entry_data_i[ENTRY_WIDTH-1:0];
  assign mem_re_o    = fire && re;
  assign mem_raddr_o = raddr;

  // Result stage valid
  always_comb begin
    if (fire)             res_vld_d = 1'b1;
    else if (res_ready_i) res_vld_d = 1'b0;
    else                  res_vld_d = res_vld_q;
  end

  // Pointers and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
      if (fire) begin
        head_q <= head_d;
        tail_q <= tail_d;
      end
    end
  end

  // Result status, payload only
  always_ff @(posedge clk_i) begin
    if (fire) begin
      meta_q.ok       <= ok;
      meta_q.rsel     <= re;
      meta_q.count    <= cnt_wide[CntOutW-1:0];
      meta_q.is_empty <= (cnt_d == '0);
      meta_q.is_full  <= (cnt_d == LastIdx);
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_meta_o  = meta_q;

endmodule

>>> hw/rtl/rqdp_skid.sv
module rqdp_skid import rqdp_pkg::*; #(
  parameter int unsigned W = OutTdataW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic         out_vld_q, skid_vld_q;
  logic [W-1:0] out_data_q, skid_data_q;
  logic         in_fire, out_free;

  // Ready comes straight from a flop
  assign in_ready_o = !skid_vld_q;
  assign in_fire    = in_valid_i && !skid_vld_q;
  assign out_free   = !out_vld_q || out_ready_i;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || in_fire;
      skid_vld_q <= 1'b0;
    end else if (in_fire) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Data path
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q)   out_data_q <= skid_data_q;
      else if (in_fire) out_data_q <= in_data_i;
    end else if (in_fire) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

>>> verif/ring_queue_drop_peek_top_test.sv
module ring_queue_drop_peek_top_test;
  import rqdp_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned ENTRY_WIDTH = 64;
  localparam int unsigned IDLE_PCT    = 13;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 10;

  // Opcodes the block does not define; it must ignore them
  localparam logic [OpW-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD_B = 3'd7;

  localparam logic [DataW-1:0] ALL_ONES = '1;

  // Status of one finished request
  typedef struct packed {
    logic               ok;
    logic [DataW-1:0]   read_data;
    logic [CntOutW-1:0] count;
    logic               is_empty;
    logic               is_full;
  } queue_status_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [63:0] entry_data, [68:64] distance, [71:69] zero
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  // [2:0] opcode
  logic [OpW-1:0]       s_axis_tuser = OP_ENQ;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [0] ok, [64:1] read_data, [68:65] count, [69] is_empty, [70] is_full, [71] zero
  logic [OutTdataW-1:0] m_axis_tdata;

  // Shadow copy of the queue
  int unsigned      head_idx = 0;
  int unsigned      tail_idx = 0;
  logic [DataW-1:0] slot_copy [DEPTH];

  queue_status_t pending_status_q[$];

  int  error_count = 0;
  int  requests_sent = 0;
  int  results_checked = 0;
  int  full_hits = 0;
  int  drops_when_full = 0;
  int  refused_enqueues = 0;
  int  peek_hits = 0;
  logic steady_flow = 1'b0;
  logic filling = 1'b1;

  ring_queue_drop_peek_top #(
    .DEPTH      (DEPTH),
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned occupancy();
    return (tail_idx + DEPTH - head_idx) % DEPTH;
  endfunction

  // Apply one request to the shadow queue and return the status it must report
  function automatic queue_status_t apply_queue_op(logic [OpW-1:0] op, logic [DataW-1:0] value,
                                                   logic [DistW-1:0] peek_dist);
    queue_status_t st;
    int unsigned   held;
    st = '0;
    held = occupancy();
    case (op)
      OP_ENQ: begin
        if (held != DEPTH - 1) begin
          tail_idx = (tail_idx + 1) % DEPTH;
          slot_copy[tail_idx] = value;
          st.ok = 1'b1;
        end else begin
          refused_enqueues++;
        end
      end
      OP_ENQ_DROP: begin
        if (held == DEPTH - 1) begin
          head_idx = (head_idx + 1) % DEPTH;
          drops_when_full++;
        end
        tail_idx = (tail_idx + 1) % DEPTH;
        slot_copy[tail_idx] = value;
        st.ok = 1'b1;
      end
      OP_DEQ: begin
        if (head_idx != tail_idx) begin
          head_idx = (head_idx + 1) % DEPTH;
          st.read_data = slot_copy[head_idx];
          st.ok = 1'b1;
        end
      end
      OP_PEEK_OLD: begin
        if (peek_dist >= 1 && peek_dist <= held) begin
          st.read_data = slot_copy[(head_idx + peek_dist) % DEPTH];
          st.ok = 1'b1;
          peek_hits++;
        end
      end
      OP_PEEK_NEW: begin
        if (peek_dist >= 1 && peek_dist <= held) begin
          st.read_data = slot_copy[(tail_idx + DEPTH + 1 - peek_dist) % DEPTH];
          st.ok = 1'b1;
          peek_hits++;
        end
      end
      OP_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
        st.ok = 1'b1;
      end
      default: ;
    endcase
    held = occupancy();
    st.count = held[CntOutW-1:0];
    st.is_empty = (held == 0);
    st.is_full = (held == DEPTH - 1);
    if (st.is_full) full_hits++;
    return st;
  endfunction

  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, results_checked);
    error_count++;
  endtask

  // Drive one request, with random idle cycles ahead of it unless in steady flow, and wait until it is taken
  task automatic send_request(logic [OpW-1:0] op, logic [DataW-1:0] value,
                              logic [DistW-1:0] peek_dist);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, peek_dist, value};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_status_q.push_back(apply_queue_op(op, value, peek_dist));
    requests_sent++;
  endtask

  // Hold the sender off until every outstanding result is back
  task automatic pause_until_drained();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_status_q.size() != 0)
      report_mismatch("results missing after drain wait", DataW'(pending_status_q.size()), '0);
  endtask

  function automatic logic [DataW-1:0] pick_entry();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // One request that wanders between empty and full, with some noise mixed in
  task automatic send_random_op();
    int unsigned      held;
    int unsigned      sel;
    logic [OpW-1:0]   op;
    logic [DistW-1:0] peek_dist;
    held = occupancy();
    if (held == DEPTH - 1 && $urandom_range(3) == 0) filling = 1'b0;
    if (held == 0) filling = 1'b1;
    if ($urandom_range(4) == 0) peek_dist = DistW'($urandom_range(31));
    else peek_dist = DistW'($urandom_range(held + 1));
    sel = $urandom_range(99);
    if (sel < 3) op = $urandom_range(1) ? OP_RSVD_A : OP_RSVD_B;
    else if (sel < 5) op = OP_CLEAR;
    else if (sel < 15) op = OP_PEEK_OLD;
    else if (sel < 25) op = OP_PEEK_NEW;
    else if (($urandom_range(9) < 7) == filling) op = $urandom_range(1) ? OP_ENQ : OP_ENQ_DROP;
    else op = OP_DEQ;
    send_request(op, pick_entry(), peek_dist);
  endtask

  // Requests on an empty queue
  task automatic test_empty_queue_ops();
    send_request(OP_DEQ, '0, 5'd0);
    send_request(OP_PEEK_OLD, '0, 5'd1);
    send_request(OP_PEEK_NEW, '0, 5'd1);
    send_request(OP_PEEK_OLD, ALL_ONES, 5'd0);
    send_request(OP_RSVD_A, ALL_ONES, 5'd31);
    send_request(OP_CLEAR, '0, 5'd0);
  endtask

  // Extreme values and peek distances at the edges of the held range
  task automatic test_edge_values();
    send_request(OP_ENQ, '0, 5'd0);
    send_request(OP_ENQ, ALL_ONES, 5'd31);
    send_request(OP_ENQ_DROP, 64'h8000_0000_0000_0001, 5'd0);
    send_request(OP_PEEK_OLD, '0, 5'd0);
    send_request(OP_PEEK_OLD, '0, 5'd1);
    send_request(OP_PEEK_OLD, '0, 5'd3);
    send_request(OP_PEEK_OLD, '0, 5'd4);
    send_request(OP_PEEK_NEW, '0, 5'd1);
    send_request(OP_PEEK_NEW, '0, 5'd3);
    send_request(OP_PEEK_NEW, '0, 5'd4);
    send_request(OP_PEEK_NEW, '0, 5'd31);
    send_request(OP_RSVD_B, ALL_ONES, 5'd16);
    send_request(OP_DEQ, '0, 5'd0);
    send_request(OP_DEQ, '0, 5'd0);
    send_request(OP_DEQ, '0, 5'd0);
    send_request(OP_DEQ, '0, 5'd0);
  endtask

  // Fill to the top, refused enqueue, drop-oldest when full, clear from full
  task automatic test_full_boundary();
    send_request(OP_CLEAR, '0, 5'd0);
    repeat (DEPTH - 1) send_request(OP_ENQ, pick_entry(), 5'd0);
    send_request(OP_ENQ, ALL_ONES, 5'd0);
    send_request(OP_ENQ_DROP, pick_entry(), 5'd0);
    send_request(OP_ENQ_DROP, pick_entry(), 5'd0);
    send_request(OP_PEEK_OLD, '0, 5'd15);
    send_request(OP_PEEK_OLD, '0, 5'd16);
    send_request(OP_PEEK_NEW, '0, 5'd15);
    send_request(OP_PEEK_NEW, '0, 5'd16);
    send_request(OP_DEQ, '0, 5'd0);
    send_request(OP_ENQ, pick_entry(), 5'd0);
    send_request(OP_CLEAR, '0, 5'd0);
    send_request(OP_DEQ, '0, 5'd0);
  endtask

  task automatic test_random_traffic(int unsigned n);
    repeat (n) send_random_op();
  endtask

  // Long run with neither side idling
  task automatic test_steady_stream(int unsigned n);
    steady_flow = 1'b1;
    repeat (n) send_random_op();
    steady_flow = 1'b0;
  endtask

  // Bursts separated by full drains of the result stream
  task automatic test_drain_pauses(int unsigned bursts);
    repeat (bursts) begin
      repeat ($urandom_range(20, 1)) send_random_op();
      pause_until_drained();
    end
  endtask

  // Result checker and receiver back-pressure
  always @(posedge clk_i) begin
    queue_status_t got;
    queue_status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok        = m_axis_tdata[0];
      got.read_data = m_axis_tdata[64:1];
      got.count     = m_axis_tdata[68:65];
      got.is_empty  = m_axis_tdata[69];
      got.is_full   = m_axis_tdata[70];
      if (pending_status_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", got.read_data, '0);
      end else begin
        want = pending_status_q.pop_front();
        if (got.ok !== want.ok) report_mismatch("ok", DataW'(got.ok), DataW'(want.ok));
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.count !== want.count)
          report_mismatch("count", DataW'(got.count), DataW'(want.count));
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", DataW'(got.is_empty), DataW'(want.is_empty));
        if (got.is_full !== want.is_full)
          report_mismatch("is_full", DataW'(got.is_full), DataW'(want.is_full));
      end
      results_checked++;
    end
    m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    int unsigned waited;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue_ops();
    test_edge_values();
    test_full_boundary();
    test_random_traffic(500);
    test_steady_stream(350);
    test_drain_pauses(20);
    test_random_traffic(300);

    // Let the pipeline empty out
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_status_q.size() != 0)
      report_mismatch("results never arrived", DataW'(pending_status_q.size()), '0);

    $display("Ran %0d requests, checked %0d results; queue full %0d times,",
             requests_sent, results_checked, full_hits);
    $display("%0d drops of the oldest entry, %0d refused enqueues, %0d peek hits",
             drops_when_full, refused_enqueues, peek_hits);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> ring_queue_drop_peek_top.f
+incdir+hw/rtl
hw/rtl/rqdp_pkg.sv
hw/rtl/rqdp_mem.sv
hw/rtl/rqdp_ctrl.sv
hw/rtl/rqdp_skid.sv
hw/rtl/ring_queue_drop_peek_top.sv
verif/ring_queue_drop_peek_top_test.sv
